[sv/pslc_pkg.sv]
// Shared types, constants and helpers for the pitch-shift loop controller.
// No dependencies; imported by pslc_div and pitch_shift_loop_controller_unit.
`default_nettype none

package pslc_pkg;

    // Divider operand widths: widest numerator is delta*32 + period
    localparam int DIV_NW = 37;
    localparam int DIV_DW = 17;

    // Default parameter values
    localparam int RING_DEPTH_DEF  = 32;
    localparam int URGENCY_MAX_DEF = 2;

    // Register reset values
    localparam logic [15:0] DELAY_STEP_RST  = 16'd32768;
    localparam logic [15:0] MIN_DELAY_RST   = 16'd64;
    localparam logic [15:0] LOWER_RST       = 16'd960;
    localparam logic [15:0] UPPER_RST       = 16'd2400;
    localparam logic [15:0] LOOP_FADE_RST   = 16'd480;
    localparam logic [15:0] ATTACK_FADE_RST = 16'd240;
    localparam logic [15:0] BAIL_FADE_RST   = 16'd960;
    localparam logic [7:0]  MARGIN_FRAC_RST = 8'd26;

    localparam logic [15:0] GAIN_ONE = 16'd32768;

    // Configuration register indexes
    typedef enum logic [2:0] {
        CFG_DELAY_STEP  = 3'd0,
        CFG_MIN_DELAY   = 3'd1,
        CFG_LOWER       = 3'd2,
        CFG_UPPER       = 3'd3,
        CFG_LOOP_FADE   = 3'd4,
        CFG_ATTACK_FADE = 3'd5,
        CFG_BAIL_FADE   = 3'd6,
        CFG_MARGIN_FRAC = 3'd7
    } cfg_idx_t;

    // Sequencer states
    typedef enum logic [3:0] {
        S_IDLE,
        S_RAMP,
        S_GAIN,
        S_EVENTS,
        S_HEAD,
        S_HCHK,
        S_TDIV,
        S_BASE,
        S_MUL,
        S_SCAN_RD,
        S_SCAN_CHK,
        S_KDIV,
        S_BAIL,
        S_DONE
    } state_t;

    // Divider request and response
    typedef struct packed {
        logic              start;
        logic [DIV_NW-1:0] num;
        logic [DIV_DW-1:0] den;
    } div_req_t;

    typedef struct packed {
        logic              done;
        logic [DIV_NW-1:0] quo;
        logic [DIV_DW-1:0] rem;
    } div_rsp_t;

    // Saturating add of a Q0.16 step to a Q16.16 delay
    function automatic logic [31:0] sat_add(input logic [31:0] d, input logic [15:0] s);
        logic [32:0] r;
        begin
            r = {1'b0, d} + {17'd0, s};
            sat_add = r[32] ? 32'hFFFF_FFFF : r[31:0];
        end
    endfunction

    // Fade length of zero is taken as one
    function automatic logic [15:0] fix_len(input logic [15:0] l);
        begin
            fix_len = (l == 16'd0) ? 16'd1 : l;
        end
    endfunction

endpackage

`default_nettype wire

[sv/pslc_div.sv]
// Restoring radix-2 divider shared by the gain, urgency and period-ratio steps.
// Depends on pslc_pkg for operand widths and the request/response structs.
`default_nettype none

module pslc_div (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire pslc_pkg::div_req_t req,
    output pslc_pkg::div_rsp_t      rsp
);
    import pslc_pkg::*;

    localparam int CNT_W = $clog2(DIV_NW + 1);

    logic              busy_reg;
    logic              done_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic [DIV_NW-1:0] quo_reg;
    logic [DIV_DW-1:0] rem_reg;
    logic [DIV_DW-1:0] den_reg;

    logic [DIV_DW:0]   shifted;
    logic [DIV_DW:0]   diff;

    // One quotient bit per cycle
    always_comb
    begin
        shifted = {rem_reg, quo_reg[DIV_NW-1]};
        diff    = shifted - {1'b0, den_reg};
    end

    // Control: start, count down, pulse done
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(DIV_NW);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Datapath: shift and subtract
    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            quo_reg <= req.num;
            rem_reg <= '0;
            den_reg <= req.den;
        end
        else if (busy_reg)
        begin
            if (!diff[DIV_DW])
            begin
                rem_reg <= diff[DIV_DW-1:0];
                quo_reg <= {quo_reg[DIV_NW-2:0], 1'b1};
            end
            else
            begin
                rem_reg <= shifted[DIV_DW-1:0];
                quo_reg <= {quo_reg[DIV_NW-2:0], 1'b0};
            end
        end
    end

    assign rsp.done = done_reg;
    assign rsp.quo  = quo_reg;
    assign rsp.rem  = rem_reg;

endmodule

`default_nettype wire

[sv/pitch_shift_loop_controller_unit.sv]
// Pitch-shift loop controller top level: sequencer, tap state, crossing ring.
// Depends on pslc_pkg and pslc_div.
//
//  channel | signals                         | direction | word
//  --------+---------------------------------+-----------+---------------------------
//  sample  | sample_valid / sample_ready     | in        | zero_cross .. period_valid
//  result  | result_valid / result_ready     | out       | tap delays, gains, flags
//  cfg     | cfg_we, cfg_index, cfg_data     | in        | one register write
//
// An item ramps the taps, records events, reads the oldest crossing and may scan
// the ring, plus one divider pass each: for the fade gain while a fade runs, for
// the urgency (then S_BASE and S_MUL for the margin) at most once per item when
// the period gate is active and UPPER exceeds LOWER, and for a gated candidate.
// Each ring entry goes through the registered read port; a step that drops entries
// without a jump rescans the ring, so the worst case is on the order of RING_DEPTH
// squared entry reads, bounded by the shared divider and the single ring read port.
// Reset needs no clearing pass; the ring is read only where written. A finished
// word waits in the output register while the next sample word is taken.
`default_nettype none

module pitch_shift_loop_controller_unit #(
    parameter int RING_DEPTH  = pslc_pkg::RING_DEPTH_DEF,
    parameter int URGENCY_MAX = pslc_pkg::URGENCY_MAX_DEF
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        sample_valid,
    output logic             sample_ready,
    input  wire logic        zero_cross,
    input  wire logic        attack,
    input  wire logic [15:0] period,
    input  wire logic [15:0] period_spread,
    input  wire logic        period_valid,
    output logic             result_valid,
    input  wire logic        result_ready,
    output logic [31:0]      tap_one_delay,
    output logic [31:0]      tap_two_delay,
    output logic [15:0]      tap_one_gain,
    output logic [15:0]      tap_two_gain,
    output logic [31:0]      latency,
    output logic             loop_fired,
    output logic             current_tap,
    output logic             bailout_fired,
    output logic             gate_chose,
    input  wire logic        cfg_we,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [15:0] cfg_data
);
    import pslc_pkg::*;

    localparam int RW       = $clog2(RING_DEPTH);
    localparam int CW       = $clog2(RING_DEPTH + 1);
    localparam int IW       = RW + 2;
    localparam int MULT_W   = 17 + $clog2(URGENCY_MAX);
    localparam int BASE_W   = 24;
    localparam int MARGIN_W = BASE_W + MULT_W - 16;
    localparam int MIS_W    = (MARGIN_W > 24) ? MARGIN_W : 24;
    localparam logic [MULT_W-1:0] URG_M1 = MULT_W'(URGENCY_MAX - 1);

    // Configuration registers
    logic [15:0] step_reg, min_delay_reg, lower_reg, upper_reg;
    logic [15:0] loop_len_reg, atk_len_reg, bail_len_reg;
    logic [7:0]  mfrac_reg;

    // Sequencer and block state
    state_t      state_reg, state_next;
    logic        zc_reg, zc_next, atk_reg, atk_next, gate_reg, gate_next;
    logic [15:0] period_reg, period_next, spread_reg, spread_next;
    logic [31:0] count_reg, count_next;
    logic [31:0] tap0_reg, tap0_next, tap1_reg, tap1_next;
    logic [15:0] gain0_reg, gain0_next, gain1_reg, gain1_next;
    logic        act_reg, act_next, fading_reg, fading_next;
    logic [15:0] elapsed_reg, elapsed_next, flen_reg, flen_next;
    logic [RW-1:0] head_reg, head_next;
    logic [CW-1:0] rcount_reg, rcount_next, i_reg, i_next;
    logic [31:0] head_at_reg, head_at_next;
    logic        fb_found_reg, fb_found_next, cand_fb_reg, cand_fb_next;
    logic [31:0] fb_d_reg, fb_d_next, cand_d_reg, cand_d_next;
    logic        margin_done_reg, margin_done_next;
    logic [16:0] t_reg, t_next;
    logic [BASE_W-1:0]   base_reg, base_next;
    logic [MULT_W-1:0]   mult_reg, mult_next;
    logic [MARGIN_W-1:0] margin_reg, margin_next;
    logic        loop_f_reg, loop_f_next, bail_f_reg, bail_f_next, gate_f_reg, gate_f_next;

    // Output register
    logic        result_valid_reg;
    logic [31:0] out_tap0_reg, out_tap1_reg, out_lat_reg;
    logic [15:0] out_gain0_reg, out_gain1_reg;
    logic        out_loop_reg, out_act_reg, out_bail_reg, out_gate_reg;
    logic        out_load;

    // Crossing ring
    logic [31:0]   ring [RING_DEPTH];
    logic [31:0]   ring_q_reg;
    logic          ring_we;
    logic [RW-1:0] ring_waddr, ring_raddr;
    logic [31:0]   ring_wdata;

    // Divider
    div_req_t div_req;
    div_rsp_t div_rsp;

    // Fade start request
    logic        fs_go;
    logic [31:0] fs_delay;
    logic [15:0] fs_len;

    // Shared combinational values
    logic [31:0]   dt;
    logic [IW-1:0] hsum, ssum;
    logic [RW-1:0] oldest_idx, scan_idx;

    pslc_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    // Active delay and ring addressing
    always_comb
    begin
        dt   = act_reg ? tap1_reg : tap0_reg;
        hsum = IW'(head_reg) + IW'(RING_DEPTH) - IW'(rcount_reg);
        if (hsum >= IW'(RING_DEPTH))
            hsum = hsum - IW'(RING_DEPTH);
        oldest_idx = hsum[RW-1:0];
        ssum = IW'(oldest_idx) + IW'(i_reg);
        if (ssum >= IW'(RING_DEPTH))
            ssum = ssum - IW'(RING_DEPTH);
        scan_idx = ssum[RW-1:0];
    end

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg      <= DELAY_STEP_RST;
            min_delay_reg <= MIN_DELAY_RST;
            lower_reg     <= LOWER_RST;
            upper_reg     <= UPPER_RST;
            loop_len_reg  <= LOOP_FADE_RST;
            atk_len_reg   <= ATTACK_FADE_RST;
            bail_len_reg  <= BAIL_FADE_RST;
            mfrac_reg     <= MARGIN_FRAC_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_idx_t'(cfg_index))
                CFG_DELAY_STEP:  step_reg      <= cfg_data;
                CFG_MIN_DELAY:   min_delay_reg <= cfg_data;
                CFG_LOWER:       lower_reg     <= cfg_data;
                CFG_UPPER:       upper_reg     <= cfg_data;
                CFG_LOOP_FADE:   loop_len_reg  <= cfg_data;
                CFG_ATTACK_FADE: atk_len_reg   <= cfg_data;
                CFG_BAIL_FADE:   bail_len_reg  <= cfg_data;
                CFG_MARGIN_FRAC: mfrac_reg     <= cfg_data[7:0];
                default:         ;
            endcase
        end
    end

    // Ring memory: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (ring_we)
            ring[ring_waddr] <= ring_wdata;
        ring_q_reg <= ring[ring_raddr];
    end

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    // Next state and datapath
    always_comb
    begin
        logic [31:0] ramp0, ramp1, hd, delta;
        logic [15:0] el1, g;
        logic [RW-1:0] h;
        logic [CW-1:0] c;
        logic        brk;
        logic [49:0] nd;
        logic [31:0] ndv;
        logic [16:0] rdiff;
        logic [15:0] mis;
        logic [BASE_W-1:0] prod_base, sb;
        logic [BASE_W+MULT_W-1:0] prod;

        state_next       = state_reg;
        zc_next          = zc_reg;
        atk_next         = atk_reg;
        gate_next        = gate_reg;
        period_next      = period_reg;
        spread_next      = spread_reg;
        count_next       = count_reg;
        tap0_next        = tap0_reg;
        tap1_next        = tap1_reg;
        gain0_next       = gain0_reg;
        gain1_next       = gain1_reg;
        act_next         = act_reg;
        fading_next      = fading_reg;
        elapsed_next     = elapsed_reg;
        flen_next        = flen_reg;
        head_next        = head_reg;
        rcount_next      = rcount_reg;
        i_next           = i_reg;
        head_at_next     = head_at_reg;
        fb_found_next    = fb_found_reg;
        fb_d_next        = fb_d_reg;
        cand_d_next      = cand_d_reg;
        cand_fb_next     = cand_fb_reg;
        margin_done_next = margin_done_reg;
        t_next           = t_reg;
        base_next        = base_reg;
        mult_next        = mult_reg;
        margin_next      = margin_reg;
        loop_f_next      = loop_f_reg;
        bail_f_next      = bail_f_reg;
        gate_f_next      = gate_f_reg;

        sample_ready = 1'b0;
        out_load     = 1'b0;
        div_req      = '0;
        ring_we      = 1'b0;
        ring_waddr   = head_reg;
        ring_wdata   = count_reg;
        ring_raddr   = oldest_idx;
        fs_go        = 1'b0;
        fs_delay     = {min_delay_reg, 16'd0};
        fs_len       = loop_len_reg;

        ramp0 = sat_add(tap0_reg, step_reg);
        ramp1 = sat_add(tap1_reg, step_reg);
        el1   = elapsed_reg + 16'd1;
        g     = div_rsp.quo[15:0];
        h     = head_reg;
        c     = rcount_reg;
        hd    = count_reg - ring_q_reg;
        brk   = hd[31] || ({hd[30:0], 16'd0} < {15'd0, dt});
        delta = ring_q_reg - head_at_reg;
        nd    = {18'd0, dt} - {{2{delta[31]}}, delta, 16'd0};
        ndv   = (nd[48:32] != 17'd0) ? 32'hFFFF_FFFF : nd[31:0];
        rdiff = (div_rsp.rem >= {1'b0, period_reg}) ? div_rsp.rem - {1'b0, period_reg}
                                                    : {1'b0, period_reg} - div_rsp.rem;
        mis   = rdiff[16:1];
        prod_base = BASE_W'(mfrac_reg) * BASE_W'(period_reg);
        sb        = {spread_reg, 8'd0};
        prod      = (BASE_W+MULT_W)'(base_reg) * (BASE_W+MULT_W)'(mult_reg);

        unique case (state_reg)
            S_IDLE:
            begin
                sample_ready = 1'b1;
                if (sample_valid)
                begin
                    zc_next          = zero_cross;
                    atk_next         = attack;
                    period_next      = period;
                    spread_next      = period_spread;
                    gate_next        = period_valid && (period > 16'd16);
                    count_next       = count_reg + 32'd1;
                    loop_f_next      = 1'b0;
                    bail_f_next      = 1'b0;
                    gate_f_next      = 1'b0;
                    margin_done_next = 1'b0;
                    state_next       = S_RAMP;
                end
            end

            // Ramp the taps and advance the fade
            S_RAMP:
            begin
                state_next = S_EVENTS;
                if (fading_reg)
                begin
                    tap0_next    = ramp0;
                    tap1_next    = ramp1;
                    elapsed_next = el1;
                    if (el1 >= flen_reg)
                    begin
                        act_next    = ~act_reg;
                        fading_next = 1'b0;
                        if (act_reg)
                        begin
                            gain0_next = GAIN_ONE;
                            gain1_next = 16'd0;
                            tap1_next  = 32'd0;
                        end
                        else
                        begin
                            gain1_next = GAIN_ONE;
                            gain0_next = 16'd0;
                            tap0_next  = 32'd0;
                        end
                    end
                    else
                    begin
                        div_req.start = 1'b1;
                        div_req.num   = DIV_NW'({el1, 15'd0});
                        div_req.den   = DIV_DW'(flen_reg);
                        state_next    = S_GAIN;
                    end
                end
                else if (act_reg)
                    tap1_next = ramp1;
                else
                    tap0_next = ramp0;
            end

            // Linear gains from the divider
            S_GAIN:
            begin
                if (div_rsp.done)
                begin
                    if (act_reg)
                    begin
                        gain0_next = g;
                        gain1_next = GAIN_ONE - g;
                    end
                    else
                    begin
                        gain1_next = g;
                        gain0_next = GAIN_ONE - g;
                    end
                    state_next = S_EVENTS;
                end
            end

            // Attack flush and crossing record
            S_EVENTS:
            begin
                if (atk_reg)
                begin
                    h      = '0;
                    c      = '0;
                    fs_go  = 1'b1;
                    fs_len = atk_len_reg;
                end
                if (zc_reg)
                begin
                    ring_we    = 1'b1;
                    ring_waddr = h;
                    h = (h == RW'(RING_DEPTH - 1)) ? '0 : h + 1'b1;
                    if (c != CW'(RING_DEPTH))
                        c = c + 1'b1;
                end
                head_next   = h;
                rcount_next = c;
                state_next  = S_HEAD;
            end

            // Read the oldest crossing
            S_HEAD:
            begin
                if (rcount_reg == '0)
                    state_next = S_BAIL;
                else
                    state_next = S_HCHK;
            end

            S_HCHK:
            begin
                head_at_next = ring_q_reg;
                if (brk)
                    state_next = S_BAIL;
                else if (fading_reg)
                begin
                    rcount_next = rcount_reg - 1'b1;
                    state_next  = S_HEAD;
                end
                else if ((dt > {lower_reg, 16'd0}) && (rcount_reg >= CW'(2)))
                begin
                    i_next        = rcount_reg - 1'b1;
                    fb_found_next = 1'b0;
                    if (gate_reg && !margin_done_reg)
                    begin
                        if (upper_reg == lower_reg)
                        begin
                            t_next     = 17'd65536;
                            state_next = S_BASE;
                        end
                        else if (upper_reg < lower_reg)
                        begin
                            t_next     = 17'd0;
                            state_next = S_BASE;
                        end
                        else
                        begin
                            div_req.start = 1'b1;
                            div_req.num   = DIV_NW'(dt - {lower_reg, 16'd0});
                            div_req.den   = DIV_DW'(upper_reg - lower_reg);
                            state_next    = S_TDIV;
                        end
                    end
                    else
                        state_next = S_SCAN_RD;
                end
                else
                begin
                    rcount_next = rcount_reg - 1'b1;
                    state_next  = S_HEAD;
                end
            end

            // Urgency, clamped to one
            S_TDIV:
            begin
                if (div_rsp.done)
                begin
                    t_next = (div_rsp.quo > DIV_NW'(65536)) ? 17'd65536 : div_rsp.quo[16:0];
                    state_next = S_BASE;
                end
            end

            S_BASE:
            begin
                base_next  = (sb > prod_base) ? sb : prod_base;
                mult_next  = MULT_W'(65536) + MULT_W'(t_reg) * URG_M1;
                state_next = S_MUL;
            end

            S_MUL:
            begin
                margin_next      = prod[BASE_W+MULT_W-1:16];
                margin_done_next = 1'b1;
                state_next       = S_SCAN_RD;
            end

            // Walk from the newest crossing toward the oldest
            S_SCAN_RD:
            begin
                ring_raddr = scan_idx;
                if (i_reg == '0)
                begin
                    rcount_next = rcount_reg - 1'b1;
                    if (fb_found_reg)
                    begin
                        fs_go       = 1'b1;
                        fs_delay    = fb_d_reg;
                        loop_f_next = 1'b1;
                        state_next  = S_BAIL;
                    end
                    else
                        state_next = S_HEAD;
                end
                else
                    state_next = S_SCAN_CHK;
            end

            S_SCAN_CHK:
            begin
                if ($signed(nd) < $signed({18'd0, min_delay_reg, 16'd0}))
                begin
                    i_next     = i_reg - 1'b1;
                    state_next = S_SCAN_RD;
                end
                else
                begin
                    if (!fb_found_reg)
                    begin
                        fb_found_next = 1'b1;
                        fb_d_next     = ndv;
                    end
                    cand_d_next  = ndv;
                    cand_fb_next = !fb_found_reg;
                    if (!gate_reg)
                    begin
                        fs_go       = 1'b1;
                        fs_delay    = ndv;
                        loop_f_next = 1'b1;
                        rcount_next = rcount_reg - 1'b1;
                        state_next  = S_BAIL;
                    end
                    else if (delta[31] || (delta == 32'd0))
                    begin
                        i_next     = i_reg - 1'b1;
                        state_next = S_SCAN_RD;
                    end
                    else
                    begin
                        div_req.start = 1'b1;
                        div_req.num   = DIV_NW'({delta[30:0], 5'd0}) + DIV_NW'(period_reg);
                        div_req.den   = {period_reg, 1'b0};
                        state_next    = S_KDIV;
                    end
                end
            end

            // Period alignment check of one candidate
            S_KDIV:
            begin
                if (div_rsp.done)
                begin
                    if ((div_rsp.quo == '0) ||
                        (MIS_W'({mis, 8'd0}) > MIS_W'(margin_reg)))
                    begin
                        i_next     = i_reg - 1'b1;
                        state_next = S_SCAN_RD;
                    end
                    else
                    begin
                        fs_go       = 1'b1;
                        fs_delay    = cand_d_reg;
                        loop_f_next = 1'b1;
                        gate_f_next = !cand_fb_reg;
                        rcount_next = rcount_reg - 1'b1;
                        state_next  = S_BAIL;
                    end
                end
            end

            // Over-threshold reset
            S_BAIL:
            begin
                if (!fading_reg && (dt > {upper_reg, 16'd0}))
                begin
                    fs_go       = 1'b1;
                    fs_len      = bail_len_reg;
                    head_next   = '0;
                    rcount_next = '0;
                    bail_f_next = 1'b1;
                end
                state_next = S_DONE;
            end

            S_DONE:
            begin
                if (!result_valid_reg || result_ready)
                begin
                    out_load   = 1'b1;
                    state_next = S_IDLE;
                end
            end

            default: state_next = S_IDLE;
        endcase

        // Start a cross-fade toward the idle tap
        if (fs_go)
        begin
            if (act_reg)
            begin
                tap0_next  = fs_delay;
                gain0_next = 16'd0;
                if (!fading_reg)
                    gain1_next = GAIN_ONE;
            end
            else
            begin
                tap1_next  = fs_delay;
                gain1_next = 16'd0;
                if (!fading_reg)
                    gain0_next = GAIN_ONE;
            end
            fading_next  = 1'b1;
            elapsed_next = 16'd0;
            flen_next    = fix_len(fs_len);
        end
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg       <= 32'd0;
            tap0_reg        <= {MIN_DELAY_RST, 16'd0};
            tap1_reg        <= 32'd0;
            gain0_reg       <= GAIN_ONE;
            gain1_reg       <= 16'd0;
            act_reg         <= 1'b0;
            fading_reg      <= 1'b0;
            elapsed_reg     <= 16'd0;
            flen_reg        <= 16'd1;
            head_reg        <= '0;
            rcount_reg      <= '0;
            margin_done_reg <= 1'b0;
            loop_f_reg      <= 1'b0;
            bail_f_reg      <= 1'b0;
            gate_f_reg      <= 1'b0;
            fb_found_reg    <= 1'b0;
        end
        else
        begin
            count_reg       <= count_next;
            tap0_reg        <= tap0_next;
            tap1_reg        <= tap1_next;
            gain0_reg       <= gain0_next;
            gain1_reg       <= gain1_next;
            act_reg         <= act_next;
            fading_reg      <= fading_next;
            elapsed_reg     <= elapsed_next;
            flen_reg        <= flen_next;
            head_reg        <= head_next;
            rcount_reg      <= rcount_next;
            margin_done_reg <= margin_done_next;
            loop_f_reg      <= loop_f_next;
            bail_f_reg      <= bail_f_next;
            gate_f_reg      <= gate_f_next;
            fb_found_reg    <= fb_found_next;
        end
    end

    // Working payload
    always_ff @(posedge clk)
    begin
        zc_reg      <= zc_next;
        atk_reg     <= atk_next;
        gate_reg    <= gate_next;
        period_reg  <= period_next;
        spread_reg  <= spread_next;
        i_reg       <= i_next;
        head_at_reg <= head_at_next;
        fb_d_reg    <= fb_d_next;
        cand_d_reg  <= cand_d_next;
        cand_fb_reg <= cand_fb_next;
        t_reg       <= t_next;
        base_reg    <= base_next;
        mult_reg    <= mult_next;
        margin_reg  <= margin_next;
    end

    // Output word: hold until taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            result_valid_reg <= 1'b0;
        else if (out_load)
            result_valid_reg <= 1'b1;
        else if (result_ready)
            result_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_tap0_reg  <= tap0_next;
            out_tap1_reg  <= tap1_next;
            out_gain0_reg <= gain0_next;
            out_gain1_reg <= gain1_next;
            out_lat_reg   <= act_next ? tap1_next : tap0_next;
            out_loop_reg  <= loop_f_next;
            out_act_reg   <= act_next;
            out_bail_reg  <= bail_f_next;
            out_gate_reg  <= gate_f_next;
        end
    end

    assign result_valid  = result_valid_reg;
    assign tap_one_delay = out_tap0_reg;
    assign tap_two_delay = out_tap1_reg;
    assign tap_one_gain  = out_gain0_reg;
    assign tap_two_gain  = out_gain1_reg;
    assign latency       = out_lat_reg;
    assign loop_fired    = out_loop_reg;
    assign current_tap   = out_act_reg;
    assign bailout_fired = out_bail_reg;
    assign gate_chose    = out_gate_reg;

    // Gains together never exceed full scale; a restart mid-fade drops the incoming one
    a_gain_sum: assert property (@(posedge clk) disable iff (!rst_n)
        ({1'b0, gain0_reg} + {1'b0, gain1_reg}) <= {1'b0, GAIN_ONE})
        else $error("tap gains exceed full scale");

    // A loop jump and a bailout never start in the same sample
    a_excl: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid_reg |-> !(out_loop_reg && out_bail_reg))
        else $error("loop and bailout in one word");

    // Period gate choice only comes with a loop jump
    a_gate: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid_reg && out_gate_reg) |-> out_loop_reg)
        else $error("gate flag without loop jump");

    // Ring fill never exceeds its depth
    a_fill: assert property (@(posedge clk) disable iff (!rst_n)
        rcount_reg <= CW'(RING_DEPTH))
        else $error("ring count overflow");

endmodule

`default_nettype wire
